/* hw/rtl/cel_pkg.sv */
// Shared types and constants for the circular event log.
// Holds the opcode and state encodings, the stored record layout and the result beat.
// No dependencies.
`default_nettype none

package cel_pkg;

    localparam logic [7:0] EMPTY_KIND  = 8'hFF;
    localparam int         RESYNC_BACK = 10;
    localparam int         DRIFT_LIMIT = 2;
    localparam int         YEAR_BASE   = 8;
    localparam int         SLOT_OUT_W  = 10;

    typedef enum logic [1:0] {
        OP_APPEND       = 2'd0,
        OP_REPORT_START = 2'd1,
        OP_REPORT_PREV  = 2'd2,
        OP_CLEAR        = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MARK  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  port;
        logic [31:0] holder;
        logic [31:0] code;
        logic [31:0] stamp;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  valid;
        rec_t                  rec;
    } res_t;

    function automatic res_t null_result(input logic [SLOT_OUT_W-1:0] slot);
        res_t r;
        r.slot       = slot;
        r.valid      = 1'b0;
        r.rec        = '0;
        r.rec.kind   = EMPTY_KIND;
        return r;
    endfunction

    function automatic res_t rec_result(input logic [SLOT_OUT_W-1:0] slot, input rec_t rec);
        res_t r;
        r.slot  = slot;
        r.valid = (rec.kind != EMPTY_KIND);
        r.rec   = rec;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/circular_event_log.sv */
// Circular event log: ring of stamped event records held in one synchronous memory.
// Depends on cel_pkg for the record layout, opcodes and state encoding.
// Top level of the block.
//
// Each accepted beat gives exactly one result beat. Append writes the record and then the
// following empty marker through the single memory write port; report previous reads the
// memory into a registered read word, then passes the result through the holding stage; start
// report and an exhausted report go straight into the holding stage. Clear answers at
// once and then sweeps every slot to empty, one slot per cycle; the same sweep runs after
// reset, and no beat is accepted during it. A result waits in a holding stage ahead of the
// output register, so one new beat is taken while an earlier result is still waiting at the
// output.
`default_nettype none

module circular_event_log
    import cel_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  event_kind,
    input  wire logic [7:0]  origin_port,
    input  wire logic [31:0] holder_id,
    input  wire logic [31:0] key_code,
    input  wire logic [6:0]  year,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    input  wire logic [4:0]  hour,
    input  wire logic [5:0]  minute,
    input  wire logic [5:0]  second,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       slot_index,
    output logic             record_valid,
    output logic [7:0]       out_kind,
    output logic [7:0]       out_port,
    output logic [31:0]      out_holder,
    output logic [31:0]      out_code,
    output logic [31:0]      out_stamp
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int XW = (AW > SLOT_OUT_W) ? AW : SLOT_OUT_W;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(LOG_DEPTH - 1);
    localparam logic [AW-1:0] BACK_SLOT  = AW'(RESYNC_BACK);
    localparam logic [AW-1:0] BACK_WRAP  = AW'(LOG_DEPTH - RESYNC_BACK);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);
    localparam logic [CW-1:0] BACK_COUNT = CW'(RESYNC_BACK);
    localparam logic [CW-1:0] DRIFT_MAX  = CW'(DRIFT_LIMIT);

    // Record memory.
    logic [REC_W-1:0] mem [LOG_DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [REC_W-1:0] mem_wdata;
    logic             mem_re;
    logic [REC_W-1:0] rd_data_reg;

    state_t        state_reg, state_next;
    logic [AW-1:0] write_slot_reg, write_slot_next;
    logic [AW-1:0] send_slot_reg, send_slot_next;
    logic [CW-1:0] unsent_reg, unsent_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [AW-1:0] report_slot_reg, report_slot_next;
    logic [CW-1:0] report_count_reg, report_count_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    res_t out_reg;
    logic out_valid_reg;
    logic res_move;

    rec_t          new_rec;
    rec_t          rd_rec;
    logic [6:0]    year_off;
    logic [AW-1:0] gap;
    logic [CW-1:0] gap_ext;
    logic [CW-1:0] drift;
    logic [AW-1:0] slot_inc;
    logic [AW-1:0] start_slot;
    logic [AW-1:0] slot_dec;
    logic [CW-1:0] unsent_mid;
    logic [XW-1:0] ws_ext, rs_ext, start_ext;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[report_slot_reg];
        end
    end

    assign year_off = year - 7'(YEAR_BASE);

    always_comb
    begin
        new_rec.kind   = event_kind;
        new_rec.port   = origin_port;
        new_rec.holder = holder_id;
        new_rec.code   = key_code;
        new_rec.stamp  = {year_off[5:0], month, day, hour, minute, second};
    end

    assign rd_rec = rec_t'(rd_data_reg);

    assign gap     = (write_slot_reg >= send_slot_reg) ? write_slot_reg - send_slot_reg
                                                       : send_slot_reg - write_slot_reg;
    assign gap_ext = CW'(gap);
    assign drift   = (unsent_reg >= gap_ext) ? unsent_reg - gap_ext : gap_ext - unsent_reg;

    assign slot_inc   = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + AW'(1);
    assign start_slot = (write_slot_reg == '0) ? LAST_SLOT : write_slot_reg - AW'(1);
    assign slot_dec   = (report_slot_reg == '0) ? LAST_SLOT : report_slot_reg - AW'(1);

    assign ws_ext    = XW'(write_slot_reg);
    assign rs_ext    = XW'(report_slot_reg);
    assign start_ext = XW'(start_slot);

    assign in_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign res_move = res_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        send_slot_next    = send_slot_reg;
        unsent_next       = unsent_reg;
        stored_next       = stored_reg;
        report_slot_next  = report_slot_reg;
        report_count_next = report_count_reg;
        sweep_next        = sweep_reg;
        mem_we            = 1'b0;
        mem_waddr         = write_slot_reg;
        mem_wdata         = '1;
        mem_re            = 1'b0;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && !res_move;
        unsent_mid        = unsent_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (op_t'(opcode))
                        OP_APPEND:
                        begin
                            // A drifted send pointer is pulled back a fixed distance.
                            if (drift > DRIFT_MAX)
                            begin
                                send_slot_next = (write_slot_reg >= BACK_SLOT)
                                               ? write_slot_reg - BACK_SLOT
                                               : write_slot_reg + BACK_WRAP;
                                unsent_mid     = BACK_COUNT;
                                stored_next    = BACK_COUNT;
                            end
                            if (stored_next < FULL_COUNT)
                            begin
                                stored_next = stored_next + CW'(1);
                            end
                            if (unsent_mid < FULL_COUNT)
                            begin
                                unsent_next = unsent_mid + CW'(1);
                            end
                            else
                            begin
                                unsent_next    = unsent_mid;
                                send_slot_next = slot_inc;
                            end
                            mem_we          = 1'b1;
                            mem_waddr       = write_slot_reg;
                            mem_wdata       = REC_W'(new_rec);
                            write_slot_next = slot_inc;
                            res_next        = rec_result(ws_ext[SLOT_OUT_W-1:0], new_rec);
                            res_valid_next  = 1'b1;
                            state_next      = ST_MARK;
                        end
                        OP_REPORT_START:
                        begin
                            report_slot_next  = start_slot;
                            report_count_next = '0;
                            res_next          = null_result(start_ext[SLOT_OUT_W-1:0]);
                            res_valid_next    = 1'b1;
                        end
                        OP_REPORT_PREV:
                        begin
                            if (report_count_reg >= FULL_COUNT || stored_reg == '0)
                            begin
                                res_next       = null_result(rs_ext[SLOT_OUT_W-1:0]);
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            send_slot_next = '0;
                            unsent_next    = '0;
                            stored_next    = '0;
                            sweep_next     = '0;
                            res_next       = null_result('0);
                            res_valid_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                // The slot after the new record becomes the empty end marker.
                mem_we     = 1'b1;
                mem_waddr  = write_slot_reg;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                res_valid_next = 1'b1;
                if (rd_rec.kind == EMPTY_KIND)
                begin
                    res_next = null_result(rs_ext[SLOT_OUT_W-1:0]);
                end
                else
                begin
                    res_next          = rec_result(rs_ext[SLOT_OUT_W-1:0], rd_rec);
                    report_count_next = report_count_reg + CW'(1);
                    report_slot_next  = slot_dec;
                end
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == LAST_SLOT)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            default:
            begin
                sweep_next = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            write_slot_reg   <= '0;
            send_slot_reg    <= '0;
            unsent_reg       <= '0;
            stored_reg       <= '0;
            report_slot_reg  <= LAST_SLOT;
            report_count_reg <= '0;
            sweep_reg        <= '0;
            res_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_slot_reg   <= write_slot_next;
            send_slot_reg    <= send_slot_next;
            unsent_reg       <= unsent_next;
            stored_reg       <= stored_next;
            report_slot_reg  <= report_slot_next;
            report_count_reg <= report_count_next;
            sweep_reg        <= sweep_next;
            res_valid_reg    <= res_valid_next;
            if (res_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (res_move)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_index   = out_reg.slot;
    assign record_valid = out_reg.valid;
    assign out_kind     = out_reg.rec.kind;
    assign out_port     = out_reg.rec.port;
    assign out_holder   = out_reg.rec.holder;
    assign out_code     = out_reg.rec.code;
    assign out_stamp    = out_reg.rec.stamp;

endmodule

`default_nettype wire
